// ===== hw/rtl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam logic [2:0] OP_LENGTH = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_QUERY  = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_PRINT  = 3'd4;

   localparam logic [31:0] NONE_VALUE = 32'hFFFF_FFFF;

   // what every cell does with its word
   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_REMOVE,
      MODE_ROTATE
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [5:0]  pos;
      logic [31:0] value;
      logic [5:0]  last;
   } cell_ctl_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_PRINT
   } state_type;

endpackage

// ===== hw/rtl/ple_cell.sv =====
`timescale 1ns / 1ps

module ple_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  ple_pkg::cell_ctl_type ctl,
   input  logic [31:0]           left_value,
   input  logic [31:0]           right_value,
   input  logic [31:0]           head_value,
   output logic [31:0]           value
);

   localparam logic [6:0] Idx = 7'(INDEX);

   logic [31:0] value_ff;
   logic [31:0] value_in;
   logic [6:0]  pos_ext;
   logic [6:0]  last_ext;

   assign pos_ext  = {1'b0, ctl.pos};
   assign last_ext = {1'b0, ctl.last};

   always_comb begin
      value_in = value_ff;
      unique case (ctl.mode)
         ple_pkg::MODE_HOLD: begin
            value_in = value_ff;
         end
         ple_pkg::MODE_INSERT: begin
            if (Idx == pos_ext) begin
               value_in = ctl.value;
            end else if (Idx > pos_ext) begin
               value_in = left_value;
            end
         end
         ple_pkg::MODE_REMOVE: begin
            if (Idx >= pos_ext) begin
               value_in = right_value;
            end
         end
         ple_pkg::MODE_ROTATE: begin
            // the tail wraps round to the head's word
            if (Idx == last_ext) begin
               value_in = head_value;
            end else begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
`timescale 1ns / 1ps

// positional list engine: keeps an ordered list of up to CAPACITY signed 32-bit words in a
// row of cells, one word per cell, and takes a command when start is high and busy is low.
// length, insert, query and remove leave the engine idle, so a new command may follow in the
// very next cycle; length and query answer with one word on rsp_strobe in the cycle after the
// command, insert and remove answer nothing. print rotates the row through cell 0 and
// shows one word per cycle, count words in all (a single -1 word on an empty list), with
// busy held high while the rotation runs; after it the list is back in its original order.
// the receiver cannot stall: every word is on the rsp_ ports for exactly one cycle.

module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [5:0]  req_position,
   input  logic [31:0] req_value_in,
   output logic        rsp_strobe,
   output logic [31:0] rsp_value_out,
   output logic        rsp_last
);

   localparam int IdxW = $clog2(CAPACITY);
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam logic [6:0] Cap = 7'(CAPACITY);

   // control state
   ple_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    remain_ff, remain_in;

   // result register
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   ple_pkg::cell_ctl_type ctl;
   logic [31:0]           cell_value [CAPACITY];

   logic       accept;
   logic [6:0] pos_ext;
   logic [6:0] cnt_ext;

   assign accept  = start && (state_ff == ple_pkg::ST_IDLE);
   assign pos_ext = {1'b0, req_position};
   assign cnt_ext = 7'(count_ff);

   // row of cells, each handing its word to a neighbour
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] left_w;
      logic [31:0] right_w;
      if (g == 0) begin : g_head
         assign left_w = cell_value[g];
      end else begin : g_mid_l
         assign left_w = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_w = cell_value[g];
      end else begin : g_mid_r
         assign right_w = cell_value[g+1];
      end
      ple_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_value (left_w),
         .right_value(right_w),
         .head_value (cell_value[0]),
         .value      (cell_value[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (accept && req_op == ple_pkg::OP_PRINT && count_ff != '0) begin
               state_in = ple_pkg::ST_PRINT;
            end
         end
         ple_pkg::ST_PRINT: begin
            if (remain_ff == CntW'(1)) begin
               state_in = ple_pkg::ST_IDLE;
            end
         end
         default: state_in = ple_pkg::ST_IDLE;
      endcase
   end

   // outputs, cell control and bookkeeping
   always_comb begin
      ctl.mode      = ple_pkg::MODE_HOLD;
      ctl.pos       = req_position;
      ctl.value     = req_value_in;
      ctl.last      = 6'(count_ff - CntW'(1));
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = ple_pkg::NONE_VALUE;
      rsp_last_in   = 1'b1;
      busy          = 1'b0;
      unique case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  ple_pkg::OP_LENGTH: begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = 32'(count_ff);
                  end
                  ple_pkg::OP_INSERT: begin
                     // ignored past the end or when full
                     if (pos_ext <= cnt_ext && cnt_ext < Cap) begin
                        ctl.mode = ple_pkg::MODE_INSERT;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  ple_pkg::OP_QUERY: begin
                     rsp_strobe_in = 1'b1;
                     if (pos_ext < cnt_ext) begin
                        rsp_value_in = cell_value[req_position[IdxW-1:0]];
                     end
                  end
                  ple_pkg::OP_REMOVE: begin
                     if (pos_ext < cnt_ext) begin
                        ctl.mode = ple_pkg::MODE_REMOVE;
                        count_in = count_ff - CntW'(1);
                     end
                  end
                  ple_pkg::OP_PRINT: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                     ctl.mode = ple_pkg::MODE_HOLD;
                  end
               endcase
            end
         end
         ple_pkg::ST_PRINT: begin
            busy          = 1'b1;
            // show the head word, then rotate the occupied cells by one
            ctl.mode      = ple_pkg::MODE_ROTATE;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = cell_value[0];
            rsp_last_in   = (remain_ff == CntW'(1));
            remain_in     = remain_ff - CntW'(1);
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ple_pkg::ST_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
